### design/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared types and constants for the gated pile-up pulse counter.
// ----------------------------------------------------------------------------
package gpc_pkg;

  // Number of detector channels in use (1 or 2)
  localparam int unsigned CHANNELS = 2;
  // Channel slots carried on the ports
  localparam int unsigned NumSlots = 2;

  localparam int unsigned CountW   = 24;
  localparam int unsigned TotalW   = 25;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned GateW    = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [TimerW-1:0] StepTicksRst = TimerW'(5500);
  localparam logic [GateW-1:0]  GateTicksRst = GateW'(10000000);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEP_TICKS = 1'b0,
    CFG_GATE_TICKS = 1'b1
  } cfg_reg_e;

  // One microsecond tick
  typedef struct packed {
    logic start_request;
    logic edge_ch0;
    logic level_ch0;
    logic edge_ch1;
    logic level_ch1;
  } tick_t;

  // One result word
  typedef struct packed {
    logic [CountW-1:0] count_ch0;
    logic [CountW-1:0] count_ch1;
    logic [TotalW-1:0] total_count;
    logic              window_active;
    logic              window_done;
    logic              display_update;
  } result_t;

  // One configuration write
  typedef struct packed {
    cfg_reg_e            index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

### design/gpc_tick_if.sv
// ----------------------------------------------------------------------------
// gpc_tick_if
// Valid/ready channel carrying one input tick word.
// ----------------------------------------------------------------------------
interface gpc_tick_if;
  import gpc_pkg::*;

  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/gpc_result_if.sv
// ----------------------------------------------------------------------------
// gpc_result_if
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface gpc_result_if;
  import gpc_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/gpc_cfg_if.sv
// ----------------------------------------------------------------------------
// gpc_cfg_if
// Valid/ready write channel for the configuration registers.
// ----------------------------------------------------------------------------
interface gpc_cfg_if;
  import gpc_pkg::*;

  logic valid;
  logic ready;
  cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/gated_pileup_pulse_counter.sv
// ----------------------------------------------------------------------------
// gated_pileup_pulse_counter
// Two-channel gated pulse counter with pile-up correction; one result word
// per tick word.
// ----------------------------------------------------------------------------
//  channel    | dir | word     | meaning
//  tick_i     | in  | tick_t   | start request, edge and level per channel
//  result_o   | out | result_t | counts, total, window status, update flag
//  cfg_i      | in  | cfg_t    | step_ticks / gate_ticks register write
//
// One tick word can be accepted every cycle. Its result word passes through
// the input register, then the single update stage into the result register.
// A result word held by the sink stalls the update stage; the input register
// still takes one word while it is empty.
// Reset clears the window, counts, timers and both pipeline stages and loads
// step_ticks = 5500, gate_ticks = 10000000. Config writes are always ready.
// ----------------------------------------------------------------------------
module gated_pileup_pulse_counter (
  input  logic         clk_i,
  input  logic         rst_ni,
  gpc_tick_if.sink     tick_i,
  gpc_result_if.source result_o,
  gpc_cfg_if.sink      cfg_i
);
  import gpc_pkg::*;

  // configuration
  logic [TimerW-1:0] step_ticks_q;
  logic [GateW-1:0]  gate_ticks_q;

  // pipeline
  logic    in_valid_q;
  tick_t   in_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    s2_fire;

  // counter state
  logic                          win_open_q, win_open_d;
  logic [GateW-1:0]              win_elapsed_q, win_elapsed_d;
  logic [NumSlots-1:0][CountW-1:0] cnt_q, cnt_d;
  logic [NumSlots-1:0][TimerW-1:0] pe_q, pe_d;
  logic [NumSlots-1:0]           hc_q, hc_d;

  logic [NumSlots-1:0] edge_v;
  logic [NumSlots-1:0] level_v;

  // handshakes
  assign cfg_i.ready    = 1'b1;
  assign s2_fire        = in_valid_q && (!out_valid_q || result_o.ready);
  assign tick_i.ready   = !in_valid_q || s2_fire;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = res_q;

  assign edge_v  = {in_q.edge_ch1, in_q.edge_ch0};
  assign level_v = {in_q.level_ch1, in_q.level_ch0};

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ticks_q <= StepTicksRst;
      gate_ticks_q <= GateTicksRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_STEP_TICKS: step_ticks_q <= cfg_i.data.data[TimerW-1:0];
        CFG_GATE_TICKS: gate_ticks_q <= cfg_i.data.data[GateW-1:0];
        default: ;
      endcase
    end
  end

  // compute next state and the result word for the tick in the input register
  always_comb begin
    logic [TimerW-1:0] inc;
    logic              hit;
    logic              upd;
    logic              done;
    win_open_d    = win_open_q;
    win_elapsed_d = win_elapsed_q;
    cnt_d         = cnt_q;
    pe_d          = pe_q;
    hc_d          = hc_q;
    upd           = 1'b0;
    done          = 1'b0;
    inc           = '0;
    hit           = 1'b0;

    // open a window: clear counts and timers
    if (!win_open_d && in_q.start_request) begin
      win_open_d    = 1'b1;
      win_elapsed_d = '0;
      cnt_d         = '0;
      pe_d          = '0;
      hc_d          = '0;
      upd           = 1'b1;
    end

    if (win_open_d) begin
      if (win_elapsed_d < gate_ticks_q) begin
        for (int ch = 0; ch < NumSlots; ch++) begin
          hit = 1'b0;
          inc = (pe_d[ch] == '1) ? pe_d[ch] : pe_d[ch] + TimerW'(1);
          if (ch < CHANNELS) begin
            if (edge_v[ch]) begin
              // new pulse: count it and restart the timer
              hit       = 1'b1;
              pe_d[ch]  = '0;
              hc_d[ch]  = 1'b1;
            end else if (hc_d[ch]) begin
              if (level_v[ch]) begin
                // pile-up: each full step_ticks of high level is one more pulse
                if (inc >= step_ticks_q) begin
                  hit      = 1'b1;
                  pe_d[ch] = inc - step_ticks_q;
                end else begin
                  pe_d[ch] = inc;
                end
              end else begin
                hc_d[ch] = 1'b0;
              end
            end
          end
          if (hit) begin
            upd = 1'b1;
            if (cnt_d[ch] != '1) begin
              cnt_d[ch] = cnt_d[ch] + CountW'(1);
            end
          end
        end
        win_elapsed_d = win_elapsed_d + GateW'(1);
      end else begin
        // close the window
        win_open_d = 1'b0;
        done       = 1'b1;
        upd        = 1'b1;
      end
    end

    res_d.count_ch0      = cnt_d[0];
    res_d.count_ch1      = cnt_d[1];
    res_d.total_count    = TotalW'(cnt_d[0]) + TotalW'(cnt_d[1]);
    res_d.window_active  = win_open_d;
    res_d.window_done    = done;
    res_d.display_update = upd;
  end

  // input register and state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      win_open_q    <= 1'b0;
      win_elapsed_q <= '0;
      cnt_q         <= '0;
      pe_q          <= '0;
      hc_q          <= '0;
    end else begin
      if (tick_i.ready) begin
        in_valid_q <= tick_i.valid;
      end
      if (s2_fire) begin
        out_valid_q   <= 1'b1;
        win_open_q    <= win_open_d;
        win_elapsed_q <= win_elapsed_d;
        cnt_q         <= cnt_d;
        pe_q          <= pe_d;
        hc_q          <= hc_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      in_q <= tick_i.data;
    end
    if (s2_fire) begin
      res_q <= res_d;
    end
  end

  // a closing tick never reports an open window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.window_done |-> !res_q.window_active)
    else $error("window_done with window_active");

  // a closing tick always flags a display update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.window_done |-> res_q.display_update)
    else $error("window_done without display_update");

  // the total matches the two channel counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      res_q.total_count == TotalW'(res_q.count_ch0) + TotalW'(res_q.count_ch1))
    else $error("total_count mismatch");

  // a start on a closed window either opens it or opens and closes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && !win_open_q && in_q.start_request |=>
      res_q.window_active || res_q.window_done)
    else $error("start request did not open a window");

  // the state only moves when a result is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_fire |=> $stable(win_elapsed_q) && $stable(cnt_q))
    else $error("state changed without a tick");

endmodule
